FILE: sv/bblur_pkg.sv
// Shared types, constants and the reciprocal table for the 3x3 box blur.
// No dependencies; bblur_ctrl, bblur_dp and the top refer to this package by scope.
package bblur_pkg;

  localparam int PIX_W       = 24;  // packed {red, green, blue}
  localparam int CH_W        = 8;
  localparam int SUM_W       = 12;  // 9 * 255 fits
  localparam int NUM_W       = 13;  // 2*sum + count
  localparam int CNT_W       = 4;   // neighbor count, 1..9
  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 20;
  localparam int PROD_W      = NUM_W + RECIP_W;

  localparam int IMG_W_BITS  = 11;
  localparam int IMG_H_BITS  = 16;
  localparam int APB_DW      = 32;
  localparam int APB_AW      = 3;

  localparam logic [IMG_W_BITS-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [IMG_H_BITS-1:0] HEIGHT_RESET = 16'd768;

  // register index, taken from paddr[2]
  localparam logic REG_IDX_WIDTH  = 1'b0;
  localparam logic REG_IDX_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PWR,
    ST_DR0,
    ST_DR1,
    ST_DR2,
    ST_DR3,
    ST_SUM_A,
    ST_EMIT_A,
    ST_SUM_B,
    ST_EMIT_B,
    ST_SUM_D,
    ST_EMIT_D
  } bblur_state_t;

  // which result is being formed: left one, row-end one, or a drain one
  typedef enum logic [1:0] {
    RSEL_A,
    RSEL_B,
    RSEL_D
  } res_sel_t;

  typedef enum logic [1:0] {
    ADDR_COL,
    ADDR_DM1,
    ADDR_D,
    ADDR_DP1
  } addr_sel_t;

  typedef struct packed {
    logic      capture;   // latch the incoming pixel
    logic      pix_wr;    // update line stores and counters
    logic      shift;     // shift the window, new column from the stores
    addr_sel_t addr_sel;
    logic      sum_en;
    res_sel_t  res_sel;
    logic      push;      // load the output register
  } bblur_cmd_t;

  typedef struct packed {
    logic pix_ok;
    logic drn_ok;
    logic has_a;
    logic has_b;
    logic pend_b;
    logic out_free;
  } bblur_status_t;

  // ceil(2^19 / cnt): floor((2s+cnt) / (2cnt)) = ((2s+cnt) * m) >> 20
  // exactly for every numerator below 2^13
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] m;
    case (cnt)
      4'd2:    m = 20'd262144;
      4'd3:    m = 20'd174763;
      4'd4:    m = 20'd131072;
      4'd5:    m = 20'd104858;
      4'd6:    m = 20'd87382;
      4'd7:    m = 20'd74899;
      4'd8:    m = 20'd65536;
      4'd9:    m = 20'd58255;
      default: m = 20'd524288;
    endcase
    return m;
  endfunction

endpackage

FILE: sv/bblur_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bblur_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/bblur_ctrl.sv
// Sequencer for the box blur: steps each request through store access and
// window shift and, where a result is due, sum and output. Depends on bblur_pkg.
module bblur_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_command,
  output logic                    in_ready,
  input  bblur_pkg::bblur_status_t st,
  output bblur_pkg::bblur_cmd_t    cmd
);

  bblur_pkg::bblur_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bblur_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.addr_sel = bblur_pkg::ADDR_COL;
    cmd.res_sel  = bblur_pkg::RSEL_A;
    in_ready     = 1'b0;
    case (state_r)
      bblur_pkg::ST_IDLE: begin
        // store read at col runs here so data is ready right after accept
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (!in_command && st.pix_ok) begin
            state_nxt = bblur_pkg::ST_PWR;
          end else if (in_command && st.drn_ok) begin
            state_nxt = bblur_pkg::ST_DR0;
          end
        end
      end
      bblur_pkg::ST_PWR: begin
        cmd.pix_wr = 1'b1;
        cmd.shift  = 1'b1;
        if (st.has_a) begin
          state_nxt = bblur_pkg::ST_SUM_A;
        end else if (st.has_b) begin
          state_nxt = bblur_pkg::ST_SUM_B;
        end else begin
          state_nxt = bblur_pkg::ST_IDLE;
        end
      end
      bblur_pkg::ST_DR0: begin
        cmd.addr_sel = bblur_pkg::ADDR_DM1;
        state_nxt    = bblur_pkg::ST_DR1;
      end
      bblur_pkg::ST_DR1: begin
        cmd.addr_sel = bblur_pkg::ADDR_D;
        cmd.shift    = 1'b1;
        state_nxt    = bblur_pkg::ST_DR2;
      end
      bblur_pkg::ST_DR2: begin
        cmd.addr_sel = bblur_pkg::ADDR_DP1;
        cmd.shift    = 1'b1;
        state_nxt    = bblur_pkg::ST_DR3;
      end
      bblur_pkg::ST_DR3: begin
        cmd.shift = 1'b1;
        state_nxt = bblur_pkg::ST_SUM_D;
      end
      bblur_pkg::ST_SUM_A: begin
        cmd.sum_en = 1'b1;
        state_nxt  = bblur_pkg::ST_EMIT_A;
      end
      bblur_pkg::ST_EMIT_A: begin
        if (st.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = st.pend_b ? bblur_pkg::ST_SUM_B : bblur_pkg::ST_IDLE;
        end
      end
      bblur_pkg::ST_SUM_B: begin
        cmd.sum_en  = 1'b1;
        cmd.res_sel = bblur_pkg::RSEL_B;
        state_nxt   = bblur_pkg::ST_EMIT_B;
      end
      bblur_pkg::ST_EMIT_B: begin
        cmd.res_sel = bblur_pkg::RSEL_B;
        if (st.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = bblur_pkg::ST_IDLE;
        end
      end
      bblur_pkg::ST_SUM_D: begin
        cmd.sum_en  = 1'b1;
        cmd.res_sel = bblur_pkg::RSEL_D;
        state_nxt   = bblur_pkg::ST_EMIT_D;
      end
      bblur_pkg::ST_EMIT_D: begin
        cmd.res_sel = bblur_pkg::RSEL_D;
        if (st.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = bblur_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bblur_pkg::ST_IDLE;
      end
    endcase
  end

  // a drain sequence only starts once all rows of the frame are in
  property p_drain_start;
    @(posedge clk) disable iff (!rst_n)
      (state_r == bblur_pkg::ST_IDLE && state_nxt == bblur_pkg::ST_DR0) |-> st.drn_ok;
  endproperty
  a_drain_start: assert property (p_drain_start) else $error("drain started early");

endmodule

FILE: sv/bblur_dp.sv
// Datapath of the box blur: line stores, 3x3 window, counters, masked
// sums, reciprocal divide and output register. Depends on bblur_pkg, bblur_ram.
module bblur_dp #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  bblur_pkg::bblur_cmd_t                cmd,
  output bblur_pkg::bblur_status_t             st,
  input  logic                                 restart,
  input  logic [bblur_pkg::IMG_W_BITS-1:0]     cfg_width,
  input  logic [bblur_pkg::IMG_H_BITS-1:0]     cfg_height,
  input  logic [bblur_pkg::CH_W-1:0]           in_red,
  input  logic [bblur_pkg::CH_W-1:0]           in_green,
  input  logic [bblur_pkg::CH_W-1:0]           in_blue,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bblur_pkg::CH_W-1:0]           out_red,
  output logic [bblur_pkg::CH_W-1:0]           out_green,
  output logic [bblur_pkg::CH_W-1:0]           out_blue,
  output logic                                 out_last_of_run,
  output logic                                 out_frame_done
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int XW = AW + 1;
  localparam int CW = (XW > bblur_pkg::IMG_W_BITS) ? XW : bblur_pkg::IMG_W_BITS;
  localparam int HW = bblur_pkg::IMG_H_BITS;
  localparam int CHW = bblur_pkg::CH_W;

  // effective frame size
  logic [CW-1:0] cfg_w_ext;
  logic [XW-1:0] w_x;
  logic [HW-1:0] h_eff;

  assign cfg_w_ext = CW'(cfg_width);
  assign w_x = (cfg_width == '0) ? XW'(1) :
               (cfg_w_ext > CW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(cfg_w_ext);
  assign h_eff = (cfg_height == '0) ? HW'(1) : cfg_height;

  // counters and per-item flags
  logic [AW-1:0] col_r, drain_r;
  logic [HW-1:0] row_r;
  logic          pend_b_r;
  logic          p_top_r, p_cge1_r, p_cge2_r;
  logic [XW-1:0] col_x, col_inc, d_x, d_inc;

  assign col_x   = XW'(col_r);
  assign col_inc = col_x + XW'(1);
  assign d_x     = XW'(drain_r);
  assign d_inc   = d_x + XW'(1);

  // line stores
  bblur_pkg::pix_t pix_r;
  bblur_pkg::pix_t older_rd, newer_rd;
  logic [AW-1:0]   rd_addr;

  always_comb begin
    unique case (cmd.addr_sel)
      bblur_pkg::ADDR_COL: rd_addr = col_r;
      bblur_pkg::ADDR_DM1: rd_addr = drain_r - AW'(1);
      bblur_pkg::ADDR_D:   rd_addr = drain_r;
      bblur_pkg::ADDR_DP1: rd_addr = drain_r + AW'(1);
    endcase
  end

  bblur_ram #(.WIDTH(bblur_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk     (clk),
    .wr_en   (cmd.pix_wr),
    .wr_addr (col_r),
    .wr_data (newer_rd),
    .rd_addr (rd_addr),
    .rd_data (older_rd)
  );

  bblur_ram #(.WIDTH(bblur_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
    .clk     (clk),
    .wr_en   (cmd.pix_wr),
    .wr_addr (col_r),
    .wr_data (pix_r),
    .rd_addr (rd_addr),
    .rd_data (newer_rd)
  );

  // window: row 0 two rows up, row 1 one row up, row 2 current; col 2 newest
  bblur_pkg::pix_t win_r [3][3];

  // masked neighborhood sum
  logic [1:0]                      rlo, rhi, clo, chi, nr, nc;
  logic [bblur_pkg::CNT_W-1:0]     cnt_c;
  logic [bblur_pkg::SUM_W-1:0]     sum_c [3];
  logic [bblur_pkg::NUM_W-1:0]     num_r [3];
  logic [bblur_pkg::RECIP_W-1:0]   recip_r;
  logic [bblur_pkg::PROD_W-1:0]    prod [3];

  always_comb begin
    case (cmd.res_sel)
      bblur_pkg::RSEL_A: begin
        rlo = p_top_r ? 2'd1 : 2'd0;
        rhi = 2'd2;
        clo = p_cge2_r ? 2'd0 : 2'd1;
        chi = 2'd2;
      end
      bblur_pkg::RSEL_B: begin
        rlo = p_top_r ? 2'd1 : 2'd0;
        rhi = 2'd2;
        clo = p_cge1_r ? 2'd1 : 2'd2;
        chi = 2'd2;
      end
      default: begin
        // drain: last row sits in row 1 of the window
        rlo = (h_eff > HW'(1)) ? 2'd0 : 2'd1;
        rhi = 2'd1;
        clo = (drain_r != '0) ? 2'd0 : 2'd1;
        chi = (d_inc < w_x) ? 2'd2 : 2'd1;
      end
    endcase
    nr    = rhi - rlo + 2'd1;
    nc    = chi - clo + 2'd1;
    cnt_c = bblur_pkg::CNT_W'(nr) * bblur_pkg::CNT_W'(nc);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_c[k] = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (2'(i) >= rlo && 2'(i) <= rhi && 2'(j) >= clo && 2'(j) <= chi) begin
            sum_c[k] = sum_c[k] + bblur_pkg::SUM_W'(win_r[i][j][CHW*(2-k) +: CHW]);
          end
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = bblur_pkg::PROD_W'(num_r[k]) * bblur_pkg::PROD_W'(recip_r);
    end
  end

  // output register
  logic                 out_valid_r, out_valid_nxt;
  bblur_pkg::pix_t      out_pix_r;
  logic                 out_last_r, out_done_r;

  assign out_valid_nxt = cmd.push ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pix_r <= {in_red, in_green, in_blue};
    end
    if (cmd.shift) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= older_rd;
      win_r[1][2] <= newer_rd;
      win_r[2][2] <= pix_r;
    end
    if (cmd.pix_wr) begin
      p_top_r  <= (row_r < HW'(2));
      p_cge1_r <= (col_r != '0);
      p_cge2_r <= (col_x >= XW'(2));
    end
    if (cmd.sum_en) begin
      for (int k = 0; k < 3; k++) begin
        num_r[k] <= bblur_pkg::NUM_W'({sum_c[k], 1'b0}) + bblur_pkg::NUM_W'(cnt_c);
      end
      recip_r <= bblur_pkg::recip(cnt_c);
    end
    if (cmd.push) begin
      for (int k = 0; k < 3; k++) begin
        out_pix_r[CHW*(2-k) +: CHW] <= prod[k][bblur_pkg::RECIP_SHIFT +: CHW];
      end
      case (cmd.res_sel)
        bblur_pkg::RSEL_A: begin
          out_last_r <= !pend_b_r;
          out_done_r <= 1'b0;
        end
        bblur_pkg::RSEL_B: begin
          out_last_r <= 1'b1;
          out_done_r <= 1'b0;
        end
        default: begin
          out_last_r <= 1'b1;
          out_done_r <= (d_x == w_x - XW'(1));
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      drain_r     <= '0;
      pend_b_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (restart) begin
        col_r   <= '0;
        row_r   <= '0;
        drain_r <= '0;
      end else begin
        if (cmd.pix_wr) begin
          pend_b_r <= st.has_b;
          if (col_inc >= w_x) begin
            col_r <= '0;
            row_r <= row_r + HW'(1);
          end else begin
            col_r <= col_inc[AW-1:0];
          end
        end
        if (cmd.push && cmd.res_sel == bblur_pkg::RSEL_D) begin
          if (d_inc >= w_x) begin
            col_r   <= '0;
            row_r   <= '0;
            drain_r <= '0;
          end else begin
            drain_r <= d_inc[AW-1:0];
          end
        end
      end
    end
  end

  assign st.pix_ok   = (row_r < h_eff);
  assign st.drn_ok   = (row_r >= h_eff) && (d_x < w_x);
  assign st.has_a    = (row_r != '0) && (col_r != '0);
  assign st.has_b    = (row_r != '0) && (col_x == w_x - XW'(1));
  assign st.pend_b   = pend_b_r;
  assign st.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_red         = out_pix_r[2*CHW +: CHW];
  assign out_green       = out_pix_r[CHW +: CHW];
  assign out_blue        = out_pix_r[0 +: CHW];
  assign out_last_of_run = out_last_r;
  assign out_frame_done  = out_done_r;

  property p_push_free;
    @(posedge clk) disable iff (!rst_n) cmd.push |-> st.out_free;
  endproperty
  a_push_free: assert property (p_push_free) else $error("result pushed over a held one");

  property p_col_range;
    @(posedge clk) disable iff (!rst_n) col_x < w_x;
  endproperty
  a_col_range: assert property (p_col_range) else $error("column count out of range");

  property p_drain_range;
    @(posedge clk) disable iff (!rst_n) d_x < w_x;
  endproperty
  a_drain_range: assert property (p_drain_range) else $error("drain count out of range");

  property p_wr_in_frame;
    @(posedge clk) disable iff (!rst_n) cmd.pix_wr |-> st.pix_ok;
  endproperty
  a_wr_in_frame: assert property (p_wr_in_frame) else $error("store write after last row");

endmodule

FILE: sv/box_blur_3x3_edge_shrink_unit.sv
// Streaming 3x3 box blur with edge shrink, RGB888, raster order.
// Requests are taken one at a time: a pixel with no result, with one result or
// two, or a drain request (three line-store reads through the one shared read address).
// Synchronous active-low reset: width 1024, height 768, frame counters zero.
// Line stores are not cleared; only entries written in the current frame are used in a sum.
module box_blur_3x3_edge_shrink_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_command,
  input  logic [bblur_pkg::CH_W-1:0]           in_red,
  input  logic [bblur_pkg::CH_W-1:0]           in_green,
  input  logic [bblur_pkg::CH_W-1:0]           in_blue,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bblur_pkg::CH_W-1:0]           out_red,
  output logic [bblur_pkg::CH_W-1:0]           out_green,
  output logic [bblur_pkg::CH_W-1:0]           out_blue,
  output logic                                 out_last_of_run,
  output logic                                 out_frame_done,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bblur_pkg::APB_AW-1:0]         paddr,
  input  logic [bblur_pkg::APB_DW-1:0]         pwdata,
  output logic [bblur_pkg::APB_DW-1:0]         prdata,
  output logic                                 pready
);

  logic [bblur_pkg::IMG_W_BITS-1:0] width_r;
  logic [bblur_pkg::IMG_H_BITS-1:0] height_r;
  logic                             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bblur_pkg::WIDTH_RESET;
      height_r <= bblur_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == bblur_pkg::REG_IDX_HEIGHT) begin
        height_r <= pwdata[bblur_pkg::IMG_H_BITS-1:0];
      end else begin
        width_r <= pwdata[bblur_pkg::IMG_W_BITS-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == bblur_pkg::REG_IDX_HEIGHT) ?
                  bblur_pkg::APB_DW'(height_r) : bblur_pkg::APB_DW'(width_r);

  bblur_pkg::bblur_cmd_t    cmd;
  bblur_pkg::bblur_status_t st;

  bblur_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .st         (st),
    .cmd        (cmd)
  );

  // any register write restarts the frame
  bblur_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .restart         (cfg_wr),
    .cfg_width       (width_r),
    .cfg_height      (height_r),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_last_of_run (out_last_of_run),
    .out_frame_done  (out_frame_done)
  );

endmodule
